### hdl/trbm_pkg.sv
// Package for the two-button relay menu controller.
// Holds the timer width, the mode type, the shared control struct and the
// seven-segment table. It depends on nothing else.
`timescale 1ns / 1ps

package trbm_pkg;

  // Width of each hold timer; the timers saturate at 2^TIMER_BITS - 1.
  localparam int TIMER_BITS = 16;
  // Width of the release wait register.
  localparam int WAIT_BITS = 16;
  // Compare width that holds both a timer and the release wait.
  localparam int CMP_BITS = (TIMER_BITS > WAIT_BITS) ? TIMER_BITS : WAIT_BITS;
  // Release wait after reset.
  localparam logic [WAIT_BITS-1:0] RELEASE_WAIT_RESET = WAIT_BITS'(29);

  // Operating modes: bit 2 set means a relay is on, bits 1:0 pick the relay.
  typedef enum logic [2:0] {
    MODE_MENU1  = 3'd0,
    MODE_MENU2  = 3'd1,
    MODE_MENU3  = 3'd2,
    MODE_MENU4  = 3'd3,
    MODE_RELAY1 = 3'd4,
    MODE_RELAY2 = 3'd5,
    MODE_RELAY3 = 3'd6,
    MODE_RELAY4 = 3'd7
  } mode_e;

  // Control for one button debouncer.
  typedef struct packed {
    logic step;     // an item is accepted this cycle
    logic enable;   // the button is evaluated in the current mode
    logic pressed;  // button level carried by the item
  } btn_ctrl_t;

  // Segment code for the menu display.
  localparam logic [6:0] SEG_MENU = 7'h40;

  // Seven-segment codes: menu dash, then digits 1 to 4.
  function automatic logic [6:0] seg_code(input logic [2:0] idx);
    logic [6:0] code;
    case (idx)
      3'd0:    code = 7'h40;
      3'd1:    code = 7'h06;
      3'd2:    code = 7'h5b;
      3'd3:    code = 7'h4f;
      3'd4:    code = 7'h66;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

### hdl/trbm_button.sv
// Debouncer for one button: armed flag and saturating hold timer.
// Uses trbm_pkg for the timer width and the control struct.
`timescale 1ns / 1ps

module trbm_button (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  trbm_pkg::btn_ctrl_t            ctrl_i,
  input  logic [trbm_pkg::WAIT_BITS-1:0] release_wait_i,
  output logic                           fire_o
);

  localparam logic [trbm_pkg::TIMER_BITS-1:0] TimerMax = '1;

  logic                            armed_q, armed_d;
  logic [trbm_pkg::TIMER_BITS-1:0] timer_q, timer_d;
  logic [trbm_pkg::TIMER_BITS-1:0] timer_inc;
  logic                            wait_over;

  // Saturating increment and the release window check.
  assign timer_inc = (timer_q == TimerMax) ? timer_q
                                           : timer_q + trbm_pkg::TIMER_BITS'(1);
  assign wait_over = trbm_pkg::CMP_BITS'(timer_inc) >
                     trbm_pkg::CMP_BITS'(release_wait_i);

  // Press arms and clears the timer; a release after the wait fires.
  always_comb begin
    armed_d = armed_q;
    timer_d = timer_q;
    fire_o  = 1'b0;
    if (ctrl_i.step) begin
      timer_d = timer_inc;
      if (ctrl_i.enable) begin
        if (!armed_q) begin
          if (ctrl_i.pressed) begin
            armed_d = 1'b1;
            timer_d = '0;
          end
        end else if (wait_over) begin
          if (ctrl_i.pressed) begin
            timer_d = '0;
          end else begin
            armed_d = 1'b0;
            fire_o  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      timer_q <= '0;
    end else begin
      armed_q <= armed_d;
      timer_q <= timer_d;
    end
  end

endmodule

### hdl/two_button_relay_menu_fsm_top.sv
// Top level of the two-button relay menu controller: mode machine, display
// register, output register and configuration. Instantiates trbm_button twice
// and uses trbm_pkg.
//
//  Channel  | Direction | Handshake                     | Payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | menu and select levels
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | relay, segments, mode
//  cfg      | in        | cfg_valid_i / cfg_ready_o     | release wait, 16 bits
//
// The button and mode update settle between the state registers and the output
// register, so one item enters per clock while the input side is not stalled.
// The input side stalls only while a result is held and m_axis_tready is low.
// Reset clears the mode, both debouncers, the display and the output valid,
// and loads the release wait with 29. Configuration is always ready.
`timescale 1ns / 1ps

module two_button_relay_menu_fsm_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] menu_pressed, [1] select_pressed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] relay_drive, [10:4] segment_pattern,
                                      // [13:11] mode_now
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  trbm_pkg::mode_e                mode_q, mode_d;
  logic [6:0]                     seg_q, seg_d;
  logic [trbm_pkg::WAIT_BITS-1:0] wait_q;
  logic                           out_valid_q;
  logic [3:0]                     relay_q, relay_d;
  logic [6:0]                     out_seg_q;
  logic [2:0]                     out_mode_q;

  logic                step;
  logic [1:0]          k;
  logic                relay_on;
  logic                menu_fire, sel_fire;
  trbm_pkg::btn_ctrl_t menu_ctrl, sel_ctrl;

  // Handshakes: a new item is taken whenever the output register can move.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign k        = mode_q[1:0];
  assign relay_on = mode_q[2];

  // The menu button only counts in menu modes; select counts in every mode.
  assign menu_ctrl = '{step: step, enable: !relay_on, pressed: s_axis_tdata[0]};
  assign sel_ctrl  = '{step: step, enable: 1'b1,      pressed: s_axis_tdata[1]};

  trbm_button u_menu_btn (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (menu_ctrl),
    .release_wait_i (wait_q),
    .fire_o         (menu_fire)
  );

  trbm_button u_sel_btn (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (sel_ctrl),
    .release_wait_i (wait_q),
    .fire_o         (sel_fire)
  );

  // Next mode. Select is taken after menu, so it wins when both fire.
  always_comb begin
    mode_d = mode_q;
    if (!relay_on) begin
      if (menu_fire) mode_d = trbm_pkg::mode_e'({1'b0, k + 2'd1});
      if (sel_fire)  mode_d = trbm_pkg::mode_e'({1'b1, k});
    end else if (sel_fire) begin
      mode_d = trbm_pkg::mode_e'({1'b0, k});
    end
  end

  // Relay drive and display pattern for the current mode.
  always_comb begin
    relay_d = 4'd0;
    seg_d   = seg_q;
    if (!relay_on) begin
      if (k == 2'd0) seg_d = trbm_pkg::SEG_MENU;
    end else if (sel_fire) begin
      seg_d = trbm_pkg::SEG_MENU;
    end else begin
      relay_d = 4'd1 << k;
      seg_d   = trbm_pkg::seg_code({1'b0, k} + 3'd1);
    end
  end

  // Control state, output valid flag and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= trbm_pkg::MODE_MENU1;
      seg_q       <= 7'h00;
      wait_q      <= trbm_pkg::RELEASE_WAIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        mode_q <= mode_d;
        seg_q  <= seg_d;
      end
      if (cfg_valid_i) wait_q <= cfg_data_i;
      if (step)               out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      relay_q    <= relay_d;
      out_seg_q  <= seg_d;
      out_mode_q <= mode_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_mode_q, out_seg_q, relay_q};

endmodule
